[hdl/four_level_page_table_walker_top_assert.svh]
// Assertion macros used by the page table walker controller.
// No dependencies; included by the files that carry assertions.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FPTW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FPTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fptw_pkg.sv]
// Shared types and codes for the page table walker.
// No dependencies; used by the controller, datapath and top level.
package fptw_pkg;

    localparam int VA_W    = 48;
    localparam int VPN_W   = 36;
    localparam int ENTRY_W = 64;
    localparam int MADDR_W = 52;
    localparam int ROOT_W  = 40;
    localparam int LVL_W   = 3;
    localparam int IDX_W   = 9;
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 368;

    localparam logic [1:0] OP_WALK  = 2'd0;
    localparam logic [1:0] OP_UNMAP = 2'd1;
    localparam logic [1:0] OP_RESP  = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_ROOT,
        ADDR_CUR,
        ADDR_NEXT
    } addr_mode_t;

    typedef struct packed {
        logic       start;
        logic       unmap_op;
        logic       capture;
        logic       advance;
        logic       save_phys;
        logic       load_out;
        logic [1:0] out_kind;
        addr_mode_t addr_mode;
        logic       use_phys;
        logic       with_entries;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic unmap;
        logic final_level;
        logic present;
        logic stop;
    } sts_t;

endpackage

[hdl/fptw_ctrl.sv]
// Walk controller: sequencing state machine and output valid.
// Depends on fptw_pkg and four_level_page_table_walker_top_assert.svh.
`include "four_level_page_table_walker_top_assert.svh"

module fptw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_op,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  fptw_pkg::sts_t    sts,
    output fptw_pkg::cmd_t    cmd
);
    import fptw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PEND
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   slot_free;
    logic   acc;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = slot_free && (state_reg != ST_PEND);
    assign acc       = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        cmd.addr_mode = ADDR_ZERO;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc && (s_op == OP_WALK || s_op == OP_UNMAP)) begin
                    cmd.start     = 1'b1;
                    cmd.unmap_op  = (s_op == OP_UNMAP);
                    cmd.load_out  = 1'b1;
                    cmd.out_kind  = KIND_READ;
                    cmd.addr_mode = ADDR_ROOT;
                    cmd.out_last  = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (acc && s_op == OP_RESP) begin
                    cmd.capture  = 1'b1;
                    cmd.load_out = 1'b1;
                    if (sts.final_level) begin
                        if (sts.unmap && sts.present) begin
                            cmd.save_phys = 1'b1;
                            cmd.out_kind  = KIND_WRITE;
                            cmd.addr_mode = ADDR_CUR;
                            state_next    = ST_PEND;
                        end else begin
                            cmd.out_kind     = KIND_DONE;
                            cmd.with_entries = 1'b1;
                            cmd.out_last     = 1'b1;
                            state_next       = ST_IDLE;
                        end
                    end else if (sts.stop) begin
                        cmd.out_kind     = KIND_DONE;
                        cmd.with_entries = 1'b1;
                        cmd.out_last     = 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        cmd.advance   = 1'b1;
                        cmd.out_kind  = KIND_READ;
                        cmd.addr_mode = ADDR_NEXT;
                        cmd.out_last  = 1'b1;
                    end
                end
            end
            ST_PEND: begin
                if (slot_free) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_kind     = KIND_DONE;
                    cmd.use_phys     = 1'b1;
                    cmd.with_entries = 1'b1;
                    cmd.out_last     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `FPTW_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load_out,
        !m_tvalid_reg || m_tready, "result register overwritten while stalled")
    `FPTW_ASSERT_NEXT(a_pend_drains, aclk, aresetn, state_reg == ST_PEND && slot_free,
        state_reg == ST_IDLE && m_tvalid_reg, "pending done result not issued")
    `FPTW_ASSERT_NEXT(a_start_issues, aclk, aresetn, state_reg == ST_IDLE && cmd.start,
        state_reg == ST_WALK && m_tvalid_reg, "walk start gave no read request")
    `FPTW_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_tvalid_reg && !m_tready,
        m_tvalid_reg, "result dropped under stall")

endmodule

[hdl/fptw_datapath.sv]
// Walk datapath: walk registers, entry address generation, result register.
// Depends on fptw_pkg; driven by fptw_ctrl commands.
module fptw_datapath #(
    parameter int LEVELS         = 4,
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fptw_pkg::ROOT_W-1:0]       cfg_root,
    input  logic [fptw_pkg::VA_W-1:0]         req_vaddr,
    input  logic [fptw_pkg::ENTRY_W-1:0]      read_data,
    input  fptw_pkg::cmd_t                    cmd,
    output fptw_pkg::sts_t                    sts,
    output logic [1:0]                        m_kind,
    output logic                              m_last,
    output logic [fptw_pkg::M_DATA_W-1:0]     m_payload
);
    import fptw_pkg::*;

    localparam logic [MADDR_W:0]   PHYS_ONE  = (MADDR_W+1)'(1) << PHYS_ADDR_BITS;
    localparam logic [MADDR_W-1:0] PHYS_MASK = MADDR_W'(PHYS_ONE - (MADDR_W+1)'(1));
    localparam logic [MADDR_W-1:0] FRAME_MASK = PHYS_MASK & ~MADDR_W'(12'hFFF);

    logic [ROOT_W-1:0]  root_frame_reg;
    logic               unmap_reg;
    logic [LVL_W-1:0]   level_reg;
    logic [VPN_W-1:0]   vpn_reg;
    logic [ROOT_W-1:0]  tbl_frame_reg;
    logic [ENTRY_W-1:0] seen_reg [4];
    logic [ENTRY_W-1:0] seen_next [4];
    logic [MADDR_W-1:0] phys_reg;

    logic [1:0]         kind_reg;
    logic               last_reg;
    logic [MADDR_W-1:0] addr_reg;
    logic [LVL_W-1:0]   lvl_out_reg;
    logic [MADDR_W-1:0] phys_out_reg;
    logic [ENTRY_W-1:0] ent_out_reg [4];

    logic [MADDR_W-1:0] entry_frame_addr;
    logic [ROOT_W-1:0]  entry_frame;
    logic [LVL_W-1:0]   level_inc;
    logic               huge_level;

    logic [VPN_W-1:0]   sel_vpn;
    logic [LVL_W-1:0]   sel_lvl;
    logic [ROOT_W-1:0]  sel_frame;
    logic [IDX_W-1:0]   sel_idx;
    logic [MADDR_W-1:0] sel_addr;

    function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                      input logic [LVL_W-1:0] lv);
        int               shift;
        logic [VPN_W-1:0] sh;
        shift = 9 * (LEVELS - int'(lv));
        if (shift > VPN_W || shift < 0) begin
            return '0;
        end
        sh = vpn >> shift;
        return sh[IDX_W-1:0];
    endfunction

    assign entry_frame_addr = read_data[MADDR_W-1:0] & FRAME_MASK;
    assign entry_frame      = entry_frame_addr[MADDR_W-1:12];
    assign level_inc        = level_reg + 3'd1;
    assign huge_level       = (level_reg > 3'd1) && (int'(level_reg) < LEVELS)
                              && (int'(level_reg) >= LEVELS - 2);

    assign sts.unmap       = unmap_reg;
    assign sts.final_level = int'(level_reg) >= LEVELS;
    assign sts.present     = read_data[0];
    assign sts.stop        = !read_data[0] || (huge_level && read_data[7]);

    // one shared index/address path for all request addresses
    always_comb begin
        case (cmd.addr_mode)
            ADDR_ROOT: begin
                sel_vpn   = req_vaddr[VA_W-1:12];
                sel_lvl   = 3'd1;
                sel_frame = root_frame_reg;
            end
            ADDR_NEXT: begin
                sel_vpn   = vpn_reg;
                sel_lvl   = level_inc;
                sel_frame = entry_frame;
            end
            default: begin
                sel_vpn   = vpn_reg;
                sel_lvl   = level_reg;
                sel_frame = tbl_frame_reg;
            end
        endcase
        sel_idx  = level_index(sel_vpn, sel_lvl);
        sel_addr = {sel_frame, sel_idx, 3'b000} & PHYS_MASK;
        if (cmd.addr_mode == ADDR_ROOT) begin
            sel_addr = sel_addr & FRAME_MASK | {40'd0, sel_idx, 3'b000} & PHYS_MASK;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            seen_next[i] = cmd.start ? '0 : seen_reg[i];
        end
        if (cmd.capture) begin
            if (int'(level_reg) == LEVELS) begin
                seen_next[3] = read_data;
            end else if (level_reg >= 3'd1 && level_reg <= 3'd3) begin
                seen_next[level_reg[1:0] - 2'd1] = read_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_frame_reg <= '0;
        end else if (cfg_we) begin
            root_frame_reg <= cfg_root;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            unmap_reg     <= cmd.unmap_op;
            level_reg     <= 3'd1;
            vpn_reg       <= req_vaddr[VA_W-1:12];
            tbl_frame_reg <= root_frame_reg;
        end else if (cmd.advance) begin
            level_reg     <= level_inc;
            tbl_frame_reg <= entry_frame;
        end
        if (cmd.save_phys) begin
            phys_reg <= entry_frame_addr;
        end
        for (int i = 0; i < 4; i++) begin
            seen_reg[i] <= seen_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            kind_reg     <= cmd.out_kind;
            last_reg     <= cmd.out_last;
            addr_reg     <= (cmd.addr_mode == ADDR_ZERO) ? '0 : sel_addr;
            lvl_out_reg  <= (cmd.addr_mode == ADDR_ZERO) ? level_reg : sel_lvl;
            phys_out_reg <= cmd.use_phys ? phys_reg : '0;
            for (int i = 0; i < 4; i++) begin
                ent_out_reg[i] <= cmd.with_entries ? seen_next[i] : '0;
            end
        end
    end

    assign m_kind    = kind_reg;
    assign m_last    = last_reg;
    assign m_payload = {5'd0, ent_out_reg[3], ent_out_reg[2], ent_out_reg[1],
                        ent_out_reg[0], phys_out_reg, lvl_out_reg, addr_reg};

endmodule

[hdl/four_level_page_table_walker_top.sv]
// Top level of the four-level page table walker.
// Depends on fptw_pkg, fptw_ctrl and fptw_datapath.
//
//  channel  | direction | handshake          | contents
//  s_       | in        | s_tvalid/s_tready  | walk, unmap or read response
//  m_       | out       | m_tvalid/m_tready  | read, write-zero or done result
//  cfg_     | in        | cfg_valid/cfg_ready| root table frame number
//
// One input request per cycle while s_tready is high; each expected one is loaded into the result register when taken.
// An unmap that clears a leaf gives two results; s_tready stays low from the
// write-zero result until it is taken and the done result is loaded.
// s_tready is low while the result register is full and m_tready is low.
// Synchronous active-low reset clears control state and the root frame.
module four_level_page_table_walker_top #(
    parameter int LEVELS         = 4,
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [47:0] req_vaddr, [111:48] read_data
    input  logic [fptw_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [51:0] mem_addr, [54:52] stop_level, [106:55] page_phys,
    // [170:107] top_entry, [234:171] second_entry, [298:235] third_entry,
    // [362:299] leaf_entry, [367:363] zero
    output logic [fptw_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fptw_pkg::ROOT_W-1:0]    cfg_data
);
    import fptw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fptw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fptw_datapath #(
        .LEVELS         (LEVELS),
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_root  (cfg_data),
        .req_vaddr (s_tdata[VA_W-1:0]),
        .read_data (s_tdata[S_DATA_W-1:VA_W]),
        .cmd       (cmd),
        .sts       (sts),
        .m_kind    (m_tuser),
        .m_last    (m_tlast),
        .m_payload (m_tdata)
    );

endmodule
